// ===== rtl/kfr_pkg.sv =====
// Shared constants, codes and types of the keyframe track resampler.
package kfr_pkg;

  localparam int MAX_KEYS   = 256;
  localparam int KEY_AW     = $clog2(MAX_KEYS);
  localparam int KEY_CW     = $clog2(MAX_KEYS + 1);

  localparam int CMD_W      = 2;
  localparam int TIME_W     = 24;
  localparam int POS_W      = 32;
  localparam int AXIS_W     = 16;
  localparam int SIDX_W     = 12;
  localparam int LEN_W      = 24;
  localparam int OCNT_W     = 13;
  localparam int T_W        = SIDX_W + LEN_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int DIV_N_W    = 48;
  localparam int DIV_D_W    = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W);

  localparam int SQ_W       = 32;
  localparam int ROOT_W     = 30;
  localparam int SQRT_V_W   = 2 * ROOT_W;
  localparam int SQRT_CNT_W = $clog2(ROOT_W);

  localparam int W_W        = 17;
  localparam logic [W_W-1:0] W_ONE = 17'h10000;

  localparam int FIELD_W    = 3;
  localparam logic [FIELD_W-1:0] FIELD_LAST_MIX  = 3'd6;
  localparam logic [FIELD_W-1:0] FIELD_LAST_AXIS = 3'd2;
  localparam logic [FIELD_W-1:0] FIELD_AXIS_BASE = 3'd4;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd1;

  localparam logic [LEN_W-1:0]  RST_TRACK_LENGTH = 24'd65536;
  localparam logic [OCNT_W-1:0] RST_OUTPUT_COUNT = 13'd20;

  localparam logic [1:0] DIV_SEL_T    = 2'd0;
  localparam logic [1:0] DIV_SEL_W    = 2'd1;
  localparam logic [1:0] DIV_SEL_NORM = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0]        key_time;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [POS_W-1:0]  angle;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
  } key_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    key_t                     key;
    logic [SIDX_W-1:0]        sample_index;
  } in_item_t;

  typedef struct packed {
    logic                     status;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [POS_W-1:0]  angle;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
  } out_item_t;

  typedef struct packed {
    logic               clear;
    logic               append;
    logic               req;
    logic               t_zero;
    logic               t_load;
    logic               div_start;
    logic [1:0]         div_sel;
    logic               srch_rd;
    logic               srch_step;
    logic               pair_rd;
    logic               w_set;
    logic               w_load;
    logic               mul;
    logic               add;
    logic               sq_clr;
    logic               sq;
    logic               sqrt_start;
    logic               norm_load;
    logic               out_load;
    logic               out_empty;
    logic [FIELD_W-1:0] field;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic multi;
    logic srch_end;
    logic srch_gt;
    logic w_need;
    logic div_done;
    logic sqrt_done;
    logic s_zero;
  } dp_stat_t;

endpackage

// ===== rtl/kfr_if.sv =====
// Handshake channel interfaces: input items, result items, configuration writes.
interface kfr_in_if import kfr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [TIME_W-1:0]        key_time;
  logic signed [POS_W-1:0]  key_pos_x;
  logic signed [POS_W-1:0]  key_pos_y;
  logic signed [POS_W-1:0]  key_pos_z;
  logic signed [POS_W-1:0]  key_angle;
  logic signed [AXIS_W-1:0] key_axis_x;
  logic signed [AXIS_W-1:0] key_axis_y;
  logic signed [AXIS_W-1:0] key_axis_z;
  logic [SIDX_W-1:0]        sample_index;

  modport source(output valid, command, key_time, key_pos_x, key_pos_y, key_pos_z,
                 key_angle, key_axis_x, key_axis_y, key_axis_z, sample_index,
                 input ready);
  modport sink(input valid, command, key_time, key_pos_x, key_pos_y, key_pos_z,
               key_angle, key_axis_x, key_axis_y, key_axis_z, sample_index,
               output ready);
endinterface

interface kfr_out_if import kfr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic signed [POS_W-1:0]  out_pos_x;
  logic signed [POS_W-1:0]  out_pos_y;
  logic signed [POS_W-1:0]  out_pos_z;
  logic signed [POS_W-1:0]  out_angle;
  logic signed [AXIS_W-1:0] out_axis_x;
  logic signed [AXIS_W-1:0] out_axis_y;
  logic signed [AXIS_W-1:0] out_axis_z;

  modport source(output valid, status, out_pos_x, out_pos_y, out_pos_z, out_angle,
                 out_axis_x, out_axis_y, out_axis_z, input ready);
  modport sink(input valid, status, out_pos_x, out_pos_y, out_pos_z, out_angle,
               out_axis_x, out_axis_y, out_axis_z, output ready);
endinterface

interface kfr_cfg_if import kfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/kfr_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module kfr_div import kfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic [DIV_N_W-1:0] quotient,
  output logic               done
);

  logic [DIV_N_W-1:0]   quo_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W-1:0]   dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_D_W:0]     part;
  logic [DIV_D_W:0]     diff;
  logic                 ge;
  logic [DIV_D_W-1:0]   rem_nxt;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    part    = {rem_r, quo_r[DIV_N_W-1]};
    diff    = part - {1'b0, dsr_r};
    ge      = (part >= {1'b0, dsr_r});
    rem_nxt = ge ? diff[DIV_D_W-1:0] : part[DIV_D_W-1:0];
  end

  // control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_N_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== rtl/kfr_sqrt.sv =====
// Bit-serial integer square root of a value scaled up by 2^28.
module kfr_sqrt import kfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic [SQRT_V_W-1:0]   v_r;
  logic [ROOT_W+1:0]     rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [ROOT_W+3:0]     part;
  logic [ROOT_W+3:0]     trial;
  logic [ROOT_W+3:0]     diff;
  logic                  ge;

  // bring down two radicand bits and test the next root bit
  always_comb begin
    part  = {rem_r, v_r[SQRT_V_W-1 -: 2]};
    trial = {2'b00, root_r, 2'b01};
    diff  = part - trial;
    ge    = (part >= trial);
  end

  // control: busy flag, step counter, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQRT_CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: radicand shifter, partial remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= {radicand, (SQRT_V_W - SQ_W)'(0)};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[SQRT_V_W-3:0], 2'b00};
      rem_r  <= ge ? diff[ROOT_W+1:0] : part[ROOT_W+1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// ===== rtl/kfr_datapath.sv =====
// Datapath: key store, configuration, search, blend, axis normalization, output register.
module kfr_datapath import kfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output out_item_t             out_item
);

  key_t                     mem [MAX_KEYS];
  key_t                     rd_a_r;
  key_t                     rd_b_r;

  logic [LEN_W-1:0]         length_r;
  logic [OCNT_W-1:0]        ocount_r;
  logic [KEY_CW-1:0]        count_r;
  logic [KEY_CW-1:0]        idx_r;
  logic [T_W-1:0]           t_r;
  logic [W_W-1:0]           w_r;
  logic signed [50:0]       prod_r;
  logic signed [POS_W-1:0]  mix_r [7];
  logic [SQ_W-1:0]          s_r;
  logic signed [AXIS_W-1:0] naxis_r [3];
  out_item_t                out_r;

  logic [KEY_CW-1:0]        last_idx;
  logic [KEY_CW-1:0]        i1;
  logic [KEY_CW-1:0]        i2;
  logic [KEY_AW-1:0]        addr_a;
  logic signed [T_W:0]      num;
  logic signed [TIME_W:0]   den;
  logic                     pos_pair;
  logic                     num_lt;

  logic [DIV_N_W-1:0]       div_dvd;
  logic [DIV_D_W-1:0]       div_dsr;
  logic [DIV_N_W-1:0]       div_q;
  logic                     div_done;
  logic [ROOT_W-1:0]        len;
  logic                     sqrt_done;

  logic signed [POS_W-1:0]  mix_a;
  logic signed [POS_W-1:0]  mix_b;
  logic signed [POS_W:0]    mix_diff;
  logic signed [51:0]       mix_sum;
  logic signed [AXIS_W-1:0] comp;
  logic signed [AXIS_W:0]   comp_x;
  logic [AXIS_W:0]          comp_mag;
  logic signed [2*AXIS_W-1:0] comp_sq;
  logic [AXIS_W-1:0]        norm_val;
  logic [FIELD_W-1:0]       axis_sel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= RST_TRACK_LENGTH;
      ocount_r <= RST_OUTPUT_COUNT;
    end else if (cfg_we) begin
      if (cfg_index == REG_TRACK_LENGTH) begin
        length_r <= cfg_data[LEN_W-1:0];
      end else if (cfg_index == REG_OUTPUT_COUNT) begin
        ocount_r <= cfg_data[OCNT_W-1:0];
      end
    end
  end

  // key count: clear, or advance on an append that fits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append && (count_r < KEY_CW'(MAX_KEYS))) begin
      count_r <= count_r + 1'b1;
    end
  end

  // key store, one write and two registered reads
  always_ff @(posedge clk) begin
    if (cmd.append && (count_r < KEY_CW'(MAX_KEYS))) begin
      mem[count_r[KEY_AW-1:0]] <= in_item.key;
    end
    if (cmd.srch_rd || cmd.pair_rd) begin
      rd_a_r <= mem[addr_a];
    end
    if (cmd.pair_rd) begin
      rd_b_r <= mem[i2[KEY_AW-1:0]];
    end
  end

  // bracketing pair, clamped at both ends
  always_comb begin
    last_idx = count_r - 1'b1;
    i1       = (idx_r == '0) ? '0 : idx_r - 1'b1;
    i2       = (idx_r > last_idx) ? last_idx : idx_r;
    addr_a   = cmd.srch_rd ? idx_r[KEY_AW-1:0] : i1[KEY_AW-1:0];
  end

  // weight test on the pair times
  always_comb begin
    num      = $signed({1'b0, t_r}) - $signed({(T_W - TIME_W + 1)'(0), rd_a_r.key_time});
    den      = $signed({1'b0, rd_b_r.key_time}) - $signed({1'b0, rd_a_r.key_time});
    pos_pair = (den > 0) && (num > 0);
    num_lt   = (num < {{(T_W - TIME_W){den[TIME_W]}}, den});
  end

  // search index and sample time
  always_ff @(posedge clk) begin
    if (cmd.req) begin
      idx_r <= '0;
    end else if (cmd.srch_step) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.t_zero) begin
      t_r <= '0;
    end else if (cmd.t_load) begin
      t_r <= div_q[T_W-1:0];
    end
  end

  // weight register
  always_ff @(posedge clk) begin
    if (cmd.w_set) begin
      w_r <= (pos_pair && !num_lt) ? W_ONE : '0;
    end else if (cmd.w_load) begin
      w_r <= div_q[W_W-1:0];
    end
  end

  // select the divider operands
  always_comb begin
    axis_sel = FIELD_AXIS_BASE + cmd.field;
    comp     = mix_r[axis_sel][AXIS_W-1:0];
    comp_x   = {comp[AXIS_W-1], comp};
    comp_mag = comp[AXIS_W-1] ? AXIS_W'(0) - comp_x : comp_x;
    comp_sq  = comp * comp;
    unique case (cmd.div_sel)
      DIV_SEL_T: begin
        div_dvd = DIV_N_W'(in_item.sample_index * length_r);
        div_dsr = DIV_D_W'(ocount_r - 1'b1);
      end
      DIV_SEL_W: begin
        div_dvd = DIV_N_W'({num[TIME_W-1:0], 16'h0000});
        div_dsr = DIV_D_W'(den[TIME_W-1:0]);
      end
      DIV_SEL_NORM: begin
        div_dvd = DIV_N_W'({comp_mag, 28'h0}) + DIV_N_W'(len >> 1);
        div_dsr = DIV_D_W'(len);
      end
      default: begin
        div_dvd = '0;
        div_dsr = '0;
      end
    endcase
  end

  kfr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_q),
    .done     (div_done)
  );

  kfr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (s_r),
    .root     (len),
    .done     (sqrt_done)
  );

  // blend operands for the current field
  always_comb begin
    unique case (cmd.field)
      3'd0: begin mix_a = rd_a_r.pos_x; mix_b = rd_b_r.pos_x; end
      3'd1: begin mix_a = rd_a_r.pos_y; mix_b = rd_b_r.pos_y; end
      3'd2: begin mix_a = rd_a_r.pos_z; mix_b = rd_b_r.pos_z; end
      3'd3: begin mix_a = rd_a_r.angle; mix_b = rd_b_r.angle; end
      3'd4: begin mix_a = POS_W'(rd_a_r.axis_x); mix_b = POS_W'(rd_b_r.axis_x); end
      3'd5: begin mix_a = POS_W'(rd_a_r.axis_y); mix_b = POS_W'(rd_b_r.axis_y); end
      3'd6: begin mix_a = POS_W'(rd_a_r.axis_z); mix_b = POS_W'(rd_b_r.axis_z); end
      default: begin mix_a = '0; mix_b = '0; end
    endcase
    mix_diff = {mix_b[POS_W-1], mix_b} - {mix_a[POS_W-1], mix_a};
    mix_sum  = $signed({{4{mix_a[POS_W-1]}}, mix_a, 16'h0000}) + 52'(prod_r)
             + 52'sd32768;
  end

  // blend: multiply step, then add and round step
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= mix_diff * $signed({1'b0, w_r});
    end
    if (cmd.add) begin
      mix_r[cmd.field] <= mix_sum[47:16];
    end
  end

  // squared axis length
  always_ff @(posedge clk) begin
    if (cmd.sq_clr) begin
      s_r <= '0;
    end else if (cmd.sq) begin
      s_r <= s_r + SQ_W'(comp_sq);
    end
  end

  // round the quotient into a saturated component
  always_comb begin
    if (comp[AXIS_W-1]) begin
      norm_val = (div_q > DIV_N_W'(32768)) ? 16'h8000 : AXIS_W'(0) - div_q[AXIS_W-1:0];
    end else begin
      norm_val = (div_q > DIV_N_W'(32767)) ? 16'h7fff : div_q[AXIS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.norm_load) begin
      naxis_r[cmd.field[1:0]] <= norm_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_empty) begin
        out_r.status <= 1'b1;
        out_r.pos_x  <= '0;
        out_r.pos_y  <= '0;
        out_r.pos_z  <= '0;
        out_r.angle  <= '0;
        out_r.axis_x <= '0;
        out_r.axis_y <= '0;
        out_r.axis_z <= '0;
      end else begin
        out_r.status <= 1'b0;
        out_r.pos_x  <= mix_r[0];
        out_r.pos_y  <= mix_r[1];
        out_r.pos_z  <= mix_r[2];
        out_r.angle  <= mix_r[3];
        out_r.axis_x <= (s_r == '0) ? '0 : naxis_r[0];
        out_r.axis_y <= (s_r == '0) ? '0 : naxis_r[1];
        out_r.axis_z <= (s_r == '0) ? '0 : naxis_r[2];
      end
    end
  end

  assign out_item = out_r;

  // status toward the controller
  always_comb begin
    stat.empty     = (count_r == '0);
    stat.multi     = (ocount_r > OCNT_W'(1));
    stat.srch_end  = (idx_r == count_r);
    stat.srch_gt   = (t_r > T_W'(rd_a_r.key_time));
    stat.w_need    = pos_pair && num_lt;
    stat.div_done  = div_done;
    stat.sqrt_done = sqrt_done;
    stat.s_zero    = (s_r == '0);
  end

endmodule

// ===== rtl/kfr_ctrl.sv =====
// Controller: sequences command handling, search, blend and normalization.
module kfr_ctrl import kfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TDIV  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_PAIR  = 4'd4;
  localparam logic [3:0] S_TIMES = 4'd5;
  localparam logic [3:0] S_WDIV  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_ADD   = 4'd8;
  localparam logic [3:0] S_SQ    = 4'd9;
  localparam logic [3:0] S_SQCHK = 4'd10;
  localparam logic [3:0] S_SQRT  = 4'd11;
  localparam logic [3:0] S_NDIV  = 4'd12;
  localparam logic [3:0] S_NWAIT = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0]         state_r, state_nxt;
  logic [FIELD_W-1:0] field_r, field_nxt;
  logic               empty_r, empty_nxt;
  logic               out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    field_nxt = field_r;
    empty_nxt = empty_r;
    cmd       = '0;
    cmd.field = field_r;
    cmd.out_empty = empty_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (in_command == CMD_APPEND) begin
            cmd.append = 1'b1;
          end else if (in_command == CMD_REQUEST) begin
            field_nxt = '0;
            if (stat.empty) begin
              empty_nxt = 1'b1;
              state_nxt = S_OUT;
            end else begin
              empty_nxt = 1'b0;
              cmd.req   = 1'b1;
              if (stat.multi) begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_T;
                state_nxt     = S_TDIV;
              end else begin
                cmd.t_zero = 1'b1;
                state_nxt  = S_SRD;
              end
            end
          end
        end
      end
      S_TDIV: begin
        if (stat.div_done) begin
          cmd.t_load = 1'b1;
          state_nxt  = S_SRD;
        end
      end
      S_SRD: begin
        if (stat.srch_end) begin
          state_nxt = S_PAIR;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SCMP;
        end
      end
      S_SCMP: begin
        if (stat.srch_gt) begin
          cmd.srch_step = 1'b1;
          state_nxt     = S_SRD;
        end else begin
          state_nxt = S_PAIR;
        end
      end
      S_PAIR: begin
        cmd.pair_rd = 1'b1;
        state_nxt   = S_TIMES;
      end
      S_TIMES: begin
        cmd.w_set = 1'b1;
        if (stat.w_need) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_W;
          state_nxt     = S_WDIV;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_WDIV: begin
        if (stat.div_done) begin
          cmd.w_load = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (field_r == FIELD_LAST_MIX) begin
          field_nxt  = '0;
          cmd.sq_clr = 1'b1;
          state_nxt  = S_SQ;
        end else begin
          field_nxt = field_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        if (field_r == FIELD_LAST_AXIS) begin
          field_nxt = '0;
          state_nxt = S_SQCHK;
        end else begin
          field_nxt = field_r + 1'b1;
        end
      end
      S_SQCHK: begin
        if (stat.s_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          state_nxt = S_NDIV;
        end
      end
      S_NDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_NORM;
        state_nxt     = S_NWAIT;
      end
      S_NWAIT: begin
        cmd.div_sel = DIV_SEL_NORM;
        if (stat.div_done) begin
          cmd.norm_load = 1'b1;
          if (field_r == FIELD_LAST_AXIS) begin
            state_nxt = S_OUT;
          end else begin
            field_nxt = field_r + 1'b1;
            state_nxt = S_NDIV;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, counter and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      field_r <= '0;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      field_r <= field_nxt;
      empty_r <= empty_nxt;
    end
  end

  // hold the result valid until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/keyframe_track_resampler_top.sv =====
// Keyframe track resampler: controller, datapath and channel hookup.
// Clear and append are handled while idle; a request on an empty track answers with an empty result.
// A request runs a key search over the keys passed, the blend, a square root and up to
// five divisions in the shared divider (sample time, weight, three axis parts).
// One item is in work at a time; rst_n (synchronous) empties the track and loads
// the register defaults; the key store itself is not cleared.
module keyframe_track_resampler_top import kfr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  kfr_in_if.sink   in_ch,
  kfr_out_if.source out_ch,
  kfr_cfg_if.sink  cfg_ch
);

  in_item_t  in_item;
  out_item_t out_item;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;

  // pack the input payload
  always_comb begin
    in_item.command      = in_ch.command;
    in_item.key.key_time = in_ch.key_time;
    in_item.key.pos_x    = in_ch.key_pos_x;
    in_item.key.pos_y    = in_ch.key_pos_y;
    in_item.key.pos_z    = in_ch.key_pos_z;
    in_item.key.angle    = in_ch.key_angle;
    in_item.key.axis_x   = in_ch.key_axis_x;
    in_item.key.axis_y   = in_ch.key_axis_y;
    in_item.key.axis_z   = in_ch.key_axis_z;
    in_item.sample_index = in_ch.sample_index;
  end

  kfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  kfr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_item  (out_item)
  );

  // channel outputs
  assign in_ch.ready       = in_ready;
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_item.status;
  assign out_ch.out_pos_x  = out_item.pos_x;
  assign out_ch.out_pos_y  = out_item.pos_y;
  assign out_ch.out_pos_z  = out_item.pos_z;
  assign out_ch.out_angle  = out_item.angle;
  assign out_ch.out_axis_x = out_item.axis_x;
  assign out_ch.out_axis_y = out_item.axis_y;
  assign out_ch.out_axis_z = out_item.axis_z;

endmodule
